/* rtl/ijenc_pkg.sv */
// Shared types and constants for the internal-code to EUC/JIS encoder.
package ijenc_pkg;

    localparam int FIFO_DEPTH_DEF = 4;

    localparam logic [7:0] CH_SI     = 8'h0F;
    localparam logic [7:0] CH_SO     = 8'h0E;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CTRL_SHOW = 8'h40;
    localparam logic [15:0] PAD_CODE = 16'h2020;
    localparam logic [7:0] KANA_LO   = 8'hA0;
    localparam logic [7:0] KANA_HI   = 8'hDF;

    localparam logic [7:0] KANJI_FINAL_RST = 8'h40;
    localparam logic [7:0] ROMAN_FINAL_RST = 8'h4A;

    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_END  = 1'b1;

    typedef enum logic [1:0] {
        CFG_TARGET_CODE,
        CFG_KANJI_FINAL,
        CFG_ROMAN_FINAL,
        CFG_SCREEN_MODE
    } cfg_index_t;

    localparam int NUM_SLOTS  = 7;
    localparam int SLOT_PRE   = 0;
    localparam int SLOT_ESC   = 1;
    localparam int SLOT_MID   = 2;
    localparam int SLOT_FINAL = 3;
    localparam int SLOT_SHIFT = 4;
    localparam int SLOT_DATA0 = 5;
    localparam int SLOT_DATA1 = 6;

    typedef struct packed {
        logic [NUM_SLOTS-1:0] mask;
        logic [7:0]           esc_mid;
        logic [7:0]           esc_final;
        logic [7:0]           shift_byte;
        logic [7:0]           data0;
        logic [7:0]           data1;
    } cmd_t;

endpackage

/* rtl/ijenc_front.sv */
// Front end: configuration registers, shift state and byte-sequence classification.
module ijenc_front import ijenc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [15:0] s_char_code,
    input  logic        q_full,
    output logic        q_push,
    output cmd_t        q_cmd
);

    logic       target_code_reg;
    logic [7:0] kanji_final_reg;
    logic [7:0] roman_final_reg;
    logic       screen_mode_reg;
    logic       kanji_shift_reg, kanji_shift_next;
    logic       kana_shift_reg, kana_shift_next;
    logic       accept;
    logic       jis;
    logic [7:0] lo;
    cmd_t       cmd;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign jis     = target_code_reg;
    assign lo      = s_char_code[7:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_code_reg <= 1'b1;
            kanji_final_reg <= KANJI_FINAL_RST;
            roman_final_reg <= ROMAN_FINAL_RST;
            screen_mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_addr))
                CFG_TARGET_CODE: target_code_reg <= cfg_wdata[0];
                CFG_KANJI_FINAL: kanji_final_reg <= cfg_wdata;
                CFG_ROMAN_FINAL: roman_final_reg <= cfg_wdata;
                CFG_SCREEN_MODE: screen_mode_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cmd              = '0;
        cmd.esc_mid      = CH_LPAREN;
        cmd.esc_final    = roman_final_reg;
        cmd.shift_byte   = CH_SI;
        kanji_shift_next = kanji_shift_reg;
        kana_shift_next  = kana_shift_reg;
        if (s_op == OP_END) begin
            if (jis && kanji_shift_reg) begin
                cmd.mask[SLOT_ESC]   = 1'b1;
                cmd.mask[SLOT_MID]   = 1'b1;
                cmd.mask[SLOT_FINAL] = 1'b1;
            end
            cmd.mask[SLOT_SHIFT] = kana_shift_reg;
            kanji_shift_next     = 1'b0;
            kana_shift_next      = 1'b0;
        end else if (s_char_code[15]) begin
            cmd.mask[SLOT_PRE]   = kana_shift_reg;
            kana_shift_next      = 1'b0;
            cmd.mask[SLOT_DATA0] = 1'b1;
            cmd.mask[SLOT_DATA1] = 1'b1;
            if (jis) begin
                if (!kanji_shift_reg) begin
                    cmd.mask[SLOT_ESC]   = 1'b1;
                    cmd.mask[SLOT_MID]   = 1'b1;
                    cmd.mask[SLOT_FINAL] = 1'b1;
                end
                cmd.esc_mid      = CH_DOLLAR;
                cmd.esc_final    = kanji_final_reg;
                kanji_shift_next = 1'b1;
                cmd.data0        = {1'b0, s_char_code[14:8]};
                cmd.data1        = {1'b0, s_char_code[6:0]};
            end else begin
                cmd.data0 = s_char_code[15:8];
                cmd.data1 = lo;
            end
        end else if (screen_mode_reg && s_char_code == PAD_CODE) begin
            cmd.mask = '0;
        end else if (screen_mode_reg && s_char_code[15:5] == '0 && lo != CH_TAB) begin
            cmd.mask[SLOT_DATA0] = 1'b1;
            cmd.mask[SLOT_DATA1] = 1'b1;
            cmd.data0            = CH_CARET;
            cmd.data1            = lo | CTRL_SHOW;
        end else begin
            if (jis && kanji_shift_reg) begin
                cmd.mask[SLOT_ESC]   = 1'b1;
                cmd.mask[SLOT_MID]   = 1'b1;
                cmd.mask[SLOT_FINAL] = 1'b1;
                kanji_shift_next     = 1'b0;
            end
            if (!kana_shift_reg && s_char_code[15:8] == '0 && lo >= KANA_LO
                    && lo <= KANA_HI) begin
                cmd.mask[SLOT_SHIFT] = 1'b1;
                cmd.shift_byte       = CH_SO;
                kana_shift_next      = 1'b1;
            end else if (kana_shift_reg && s_char_code[15:7] == '0) begin
                cmd.mask[SLOT_SHIFT] = 1'b1;
                kana_shift_next      = 1'b0;
            end
            cmd.mask[SLOT_DATA0] = 1'b1;
            cmd.data0            = {1'b0, s_char_code[6:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kanji_shift_reg <= 1'b0;
            kana_shift_reg  <= 1'b0;
        end else if (accept) begin
            kanji_shift_reg <= kanji_shift_next;
            kana_shift_reg  <= kana_shift_next;
        end
    end

    assign q_push = accept && (cmd.mask != '0);
    assign q_cmd  = cmd;

endmodule

/* rtl/ijenc_fifo.sv */
// Short command queue between the front end and the byte serializer.
module ijenc_fifo import ijenc_pkg::*; #(
    parameter int Depth = FIFO_DEPTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic empty,
    output cmd_t head_cmd
);

    localparam int PtrW = $clog2(Depth);
    localparam int CntW = $clog2(Depth + 1);

    cmd_t            mem [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    assign full     = (count_reg == CntW'(Depth));
    assign empty    = (count_reg == '0);
    assign head_cmd = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* rtl/ijenc_back.sv */
// Back end: walks the enabled byte slots of each command into the output register.
module ijenc_back import ijenc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_empty,
    input  cmd_t       q_head,
    output logic       q_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_last
);

    logic [NUM_SLOTS-1:0] done_reg, done_next;
    logic [NUM_SLOTS-1:0] pending;
    logic [NUM_SLOTS-1:0] sel;
    logic [NUM_SLOTS-1:0] rest;
    logic [7:0]           slot_byte [NUM_SLOTS];
    logic [7:0]           byte_sel;
    logic                 emit;
    logic                 is_last;
    logic                 m_valid_reg;
    logic [7:0]           m_out_byte_reg;
    logic                 m_last_reg;

    assign pending = q_head.mask & ~done_reg;
    assign sel     = pending & (~pending + 1'b1);
    assign rest    = pending & ~sel;
    assign is_last = (rest == '0);
    assign emit    = !q_empty && (!m_valid_reg || m_ready);
    assign q_pop   = emit && is_last;

    always_comb begin
        slot_byte[SLOT_PRE]   = CH_SI;
        slot_byte[SLOT_ESC]   = CH_ESC;
        slot_byte[SLOT_MID]   = q_head.esc_mid;
        slot_byte[SLOT_FINAL] = q_head.esc_final;
        slot_byte[SLOT_SHIFT] = q_head.shift_byte;
        slot_byte[SLOT_DATA0] = q_head.data0;
        slot_byte[SLOT_DATA1] = q_head.data1;
    end

    always_comb begin
        byte_sel = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (sel[i]) begin
                byte_sel = slot_byte[i];
            end
        end
    end

    always_comb begin
        done_next = done_reg;
        if (emit) begin
            done_next = is_last ? '0 : (done_reg | sel);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            done_reg <= done_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_out_byte_reg <= byte_sel;
            m_last_reg     <= is_last;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_out_byte_reg;
    assign m_last     = m_last_reg;

endmodule

/* rtl/internal_to_euc_jis_encoder.sv */
// Top level of the internal-code to EUC/JIS byte-stream encoder.
// An item's first byte passes the command queue, then the output register.
// Throughput: one input item per cycle while the command queue has room, and one
// output byte per cycle while m_ready allows; a command pops with its last byte.
// Reset (aresetn, synchronous, active low) empties the queue and output register,
// clears both shift flags and restores the configuration registers to defaults.
module internal_to_euc_jis_encoder import ijenc_pkg::*; #(
    parameter int FifoDepth = FIFO_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [15:0] s_char_code,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_last
);

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    cmd_t q_in;
    cmd_t q_head;

    ijenc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_char_code (s_char_code),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (q_in)
    );

    ijenc_fifo #(
        .Depth (FifoDepth)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_in),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head_cmd (q_head)
    );

    ijenc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_last     (m_last)
    );

endmodule
